// ===== hw/rtl/keypad_matrix_toggle_debouncer_top_defines.svh =====
// ============================================================================
// Keypad matrix toggle debouncer assertion macros
// Concurrent check wrappers; empty bodies for synthesis builds.
// ============================================================================
`ifndef KEYPAD_MATRIX_TOGGLE_DEBOUNCER_TOP_DEFINES_SVH
`define KEYPAD_MATRIX_TOGGLE_DEBOUNCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check with reset disable
`define KMTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds during reset
`define KMTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KMTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/kmtd_pkg.sv =====
// ============================================================================
// Keypad matrix toggle debouncer package
// Shared widths, defaults, register map and result word type.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kmtd_pkg;

    localparam int KEY_W    = 16;
    localparam int SLOT_W   = 36;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int IN_TDW   = 16;
    localparam int OUT_TDW  = 48;

    localparam int DEF_ROWS       = 4;
    localparam int DEF_COLS       = 4;
    localparam int DEF_ROW_STRIDE = 9;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;

    // register index = paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef struct packed {
        logic              busy;
        logic [IDX_W-1:0]  toggled_index;
        logic              toggled;
        logic [SLOT_W-1:0] switch_states;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/kmtd_apb.sv =====
// ============================================================================
// Keypad debouncer config registers
// APB slave holding the debounce tick limit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kmtd_apb (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kmtd_pkg::APB_AW-1:0] paddr,
    input  wire logic [kmtd_pkg::APB_DW-1:0] pwdata,
    output logic      [kmtd_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output logic      [kmtd_pkg::CFG_W-1:0]  o_debounce_ticks
);
    import kmtd_pkg::*;

    logic [CFG_W-1:0] r_debounce;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEBOUNCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (wr_en) begin
            r_debounce <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DEBOUNCE) begin
            prdata = APB_DW'(r_debounce);
        end
    end

    assign o_debounce_ticks = r_debounce;

endmodule

`default_nettype wire

// ===== hw/rtl/kmtd_core.sv =====
// ============================================================================
// Keypad debouncer step logic
// Debounce/release state and per-tick scan, toggle and result build.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_matrix_toggle_debouncer_top_defines.svh"

module kmtd_core #(
    parameter int ROWS       = kmtd_pkg::DEF_ROWS,
    parameter int COLS       = kmtd_pkg::DEF_COLS,
    parameter int ROW_STRIDE = kmtd_pkg::DEF_ROW_STRIDE
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [kmtd_pkg::KEY_W-1:0] i_keys,
    input  wire logic [kmtd_pkg::CFG_W-1:0] i_debounce_ticks,
    output kmtd_pkg::t_result               o_res
);
    import kmtd_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int EXT_W = (ROWS * COLS > KEY_W) ? ROWS * COLS : KEY_W;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_RELEASE  = 2'd2;

    logic [1:0]        r_phase,  n_phase;
    logic [CFG_W-1:0]  r_count,  n_count;
    logic [RW-1:0]     r_row,    n_row;
    logic [CW-1:0]     r_col,    n_col;
    logic [SLOT_W-1:0] r_latch,  n_latch;

    logic [EXT_W-1:0]  keys_ext;
    logic              press [0:(1<<RW)-1][0:(1<<CW)-1];
    logic              row_hit;
    logic [RW-1:0]     hit_row;
    logic              check;
    logic              scan_hit;
    logic [CW-1:0]     scan_col;
    logic              scan_tog;
    logic [IDX_W-1:0]  scan_idx;
    logic              tog;
    logic [IDX_W-1:0]  tidx;

    assign keys_ext = EXT_W'(i_keys);

    always_comb begin
        for (int r = 0; r < (1 << RW); r++) begin
            for (int c = 0; c < (1 << CW); c++) begin
                press[r][c] = 1'b0;
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                press[r][c] = keys_ext[r*COLS+c];
            end
        end
    end

    // lowest row holding a press
    always_comb begin
        row_hit = 1'b0;
        hit_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            for (int c = 0; c < COLS; c++) begin
                if (press[r][c]) begin
                    row_hit = 1'b1;
                    hit_row = RW'(r);
                end
            end
        end
    end

    // column-major first press
    always_comb begin
        scan_hit = 1'b0;
        scan_col = '0;
        scan_tog = 1'b0;
        scan_idx = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            for (int r = ROWS - 1; r >= 0; r--) begin
                if (press[r][c]) begin
                    scan_hit = 1'b1;
                    scan_col = CW'(c);
                    if (r * ROW_STRIDE + c < SLOT_W) begin
                        scan_tog = 1'b1;
                        scan_idx = IDX_W'(r * ROW_STRIDE + c);
                    end else begin
                        scan_tog = 1'b0;
                        scan_idx = '0;
                    end
                end
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_row   = r_row;
        n_col   = r_col;
        n_latch = r_latch;
        check   = 1'b0;
        tog     = 1'b0;
        tidx    = '0;

        unique case (r_phase)
            PH_DEBOUNCE: begin
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                check = 1'b1;
            end
            PH_RELEASE: begin
                if (!press[r_row][r_col]) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (row_hit) begin
                    n_row   = hit_row;
                    n_count = '0;
                    n_phase = PH_DEBOUNCE;
                    check   = 1'b1;
                end
            end
        endcase

        if (check && (n_count >= i_debounce_ticks)) begin
            if (scan_hit) begin
                n_col = scan_col;
                if (scan_tog) begin
                    tog     = 1'b1;
                    tidx    = scan_idx;
                    n_latch = r_latch ^ (SLOT_W'(1) << scan_idx);
                end
            end
            n_phase = press[n_row][n_col] ? PH_RELEASE : PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_latch <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_row   <= n_row;
            r_col   <= n_col;
            r_latch <= n_latch;
        end
    end

    assign o_res.switch_states = n_latch;
    assign o_res.toggled       = tog;
    assign o_res.toggled_index = tidx;
    assign o_res.busy          = (n_phase == PH_DEBOUNCE) || (n_phase == PH_RELEASE);

    `KMTD_ASSERT(a_hold_idle, i_clk, i_rst_n, $past(i_rst_n) && !$past(i_fire) |-> $stable(r_latch) && $stable(r_phase), "state changed without a word")
    `KMTD_ASSERT(a_toggle_flip, i_clk, i_rst_n, i_fire && tog |=> $countones(r_latch ^ $past(r_latch)) == 1, "toggle did not flip exactly one bit")
    `KMTD_ASSERT(a_no_toggle, i_clk, i_rst_n, i_fire && !tog |=> r_latch == $past(r_latch), "latch changed without toggle")
    `KMTD_ASSERT(a_toggle_check, i_clk, i_rst_n, tog |-> check && (tidx < SLOT_W), "toggle outside a scan")
    `KMTD_ASSERT_ALWAYS(a_phase_code, i_clk, !i_rst_n || (r_phase != 2'd3) || !$past(i_rst_n), "unused phase code reached")

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_matrix_toggle_debouncer_top.sv =====
// ============================================================================
// Keypad matrix toggle debouncer
// Stream wrapper: input word register, step logic, result word register.
// ============================================================================
// Each input word is one tick snapshot of the key matrix and yields exactly one
// result word. A new word is accepted every cycle while the output is not
// stalled; its result word passes the input register, then the result
// register, and is held there until taken. The result register decouples the
// sides, so a stalled output still lets one more word enter. Configuration is
// a single APB register (debounce_ticks, offset 0).
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_toggle_debouncer_top #(
    parameter int ROWS       = kmtd_pkg::DEF_ROWS,
    parameter int COLS       = kmtd_pkg::DEF_COLS,
    parameter int ROW_STRIDE = kmtd_pkg::DEF_ROW_STRIDE
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] key_pressed
    input  wire logic [kmtd_pkg::IN_TDW-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [35:0] switch_states, [36] toggled, [42:37] toggled_index, [43] busy_res
    output logic      [kmtd_pkg::OUT_TDW-1:0] m_axis_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kmtd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [kmtd_pkg::APB_DW-1:0]  pwdata,
    output logic      [kmtd_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);
    import kmtd_pkg::*;

    logic             r_in_valid;
    logic [KEY_W-1:0] r_keys;
    logic             r_out_valid;
    t_result          r_out;
    t_result          res;
    logic             fire;
    logic [CFG_W-1:0] debounce_ticks;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    kmtd_apb u_apb (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_debounce_ticks (debounce_ticks)
    );

    kmtd_core #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .ROW_STRIDE (ROW_STRIDE)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_keys           (r_keys),
        .i_debounce_ticks (debounce_ticks),
        .o_res            (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_keys <= s_axis_tdata[KEY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDW'(r_out);

endmodule

`default_nettype wire
